/* hw/rtl/xmb64_pkg.sv */
// Shared types, constants and the base64 character map for the XOR-masked
// base64 decoder. No dependencies; every other file uses it by scoped names.
package xmb64_pkg;

  localparam int KeyBytes   = 32;
  localparam int KeyIdxW    = $clog2(KeyBytes);
  localparam int KeyWords   = 4;
  localparam int KeyWordW   = 64;
  localparam int CfgIdxW    = 3;
  localparam int SextetW    = 6;
  localparam int AccW       = 18;
  localparam int GroupW     = 24;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 3'd3;

  // Sextet slot that closes a group, and byte slot that closes a group
  localparam logic [1:0] GroupFullPos = 2'd3;
  localparam logic [1:0] LastByteSel  = 2'd2;

  typedef logic [KeyIdxW-1:0] key_idx_t;
  typedef logic [KeyBytes-1:0][7:0] key_t;

  // One completed 24-bit group handed from front to back
  typedef struct packed {
    logic [GroupW-1:0] word;
    key_idx_t          key_base;
    logic              last;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Map an unmasked character to its 6-bit value; anything else is zero
  function automatic logic [SextetW-1:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      v = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = c - 8'd71;
    end else if (c inside {[8'h30:8'h39]}) begin
      v = c + 8'd4;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end
    return v[SextetW-1:0];
  endfunction

endpackage

/* hw/rtl/xor_masked_base64_decoder_top.sv */
// Top level of the XOR-masked base64 decoder: key registers, front end,
// group queue and back end. Uses xmb64_pkg, xmb64_front, xmb64_queue, xmb64_back.
//
// The decoder takes one masked text byte per cycle and, for every fourth byte,
// emits three plain bytes one per cycle, while plain_stall is low, from a
// registered output, so a steady stream runs at one text byte per cycle.
// A two-group queue sits between the front end that packs sextets and the back
// end that serializes bytes; text_stall rises only when a byte that closes a
// group meets a full queue. The user must write the key through the cfg port
// only while no resource is in flight; the block does not enforce it. A
// trailing partial group is dropped.
module xor_masked_base64_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [xmb64_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [xmb64_pkg::KeyWordW-1:0]    cfg_data,
  input  logic                              text_valid,
  input  logic [7:0]                        text_byte,
  input  logic                              text_last,
  output logic                              text_stall,
  output logic                              plain_valid,
  output logic [7:0]                        plain_byte,
  output logic                              plain_last,
  input  logic                              plain_stall
);

  logic [xmb64_pkg::KeyWords-1:0][xmb64_pkg::KeyWordW-1:0] key_word;
  xmb64_pkg::key_t      key;
  xmb64_pkg::group_t    q_entry;
  xmb64_pkg::group_t    q_head;
  xmb64_pkg::q_status_t q_status;
  logic                 q_push;
  logic                 q_pop;
  logic                 cfg_hit;

  assign key     = key_word;
  assign cfg_hit = cfg_write && (cfg_index <= xmb64_pkg::CfgKeyWord3);

  // Hold the key words
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        xmb64_pkg::CfgKeyWord0: key_word[0] <= cfg_data;
        xmb64_pkg::CfgKeyWord1: key_word[1] <= cfg_data;
        xmb64_pkg::CfgKeyWord2: key_word[2] <= cfg_data;
        xmb64_pkg::CfgKeyWord3: key_word[3] <= cfg_data;
        default:                key_word    <= key_word;
      endcase
    end
  end

  xmb64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .text_valid (text_valid),
    .text_byte  (text_byte),
    .text_last  (text_last),
    .text_stall (text_stall),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  xmb64_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  xmb64_back u_back (
    .clk         (clk),
    .rst         (rst),
    .key         (key),
    .q_head      (q_head),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .plain_valid (plain_valid),
    .plain_byte  (plain_byte),
    .plain_stall (plain_stall),
    .plain_last  (plain_last)
  );

`ifndef NO_ASSERTIONS
  // Never push a group into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("group pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_status.empty))
    else $error("group popped from empty queue");

  // When the final group of a resource leaves the queue, its third byte is loaded with plain_last set
  a_pop_loads_last: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.last) |=> (plain_valid && plain_last))
    else $error("closing byte of final group not flagged");
`endif

endmodule

/* hw/rtl/xmb64_front.sv */
// Front end: accepts masked text bytes, unmasks and maps them to sextets and
// packs four sextets into a group for the queue. Uses xmb64_pkg.
module xmb64_front (
  input  logic                  clk,
  input  logic                  rst,
  input  xmb64_pkg::key_t       key,
  input  logic                  text_valid,
  input  logic [7:0]            text_byte,
  input  logic                  text_last,
  output logic                  text_stall,
  input  xmb64_pkg::q_status_t  q_status,
  output logic                  q_push,
  output xmb64_pkg::group_t     q_entry
);

  logic [xmb64_pkg::AccW-1:0]    acc;
  logic [1:0]                    pos;
  xmb64_pkg::key_idx_t           in_idx;
  xmb64_pkg::key_idx_t           out_idx;
  logic [7:0]                    plain_char;
  logic [xmb64_pkg::SextetW-1:0] sextet;
  logic                          accept;
  logic                          group_done;

  // Unmask and classify the incoming character
  always_comb begin
    plain_char = text_byte ^ key[in_idx];
    sextet     = xmb64_pkg::sextet_of(plain_char);
    group_done = (pos == xmb64_pkg::GroupFullPos);
    text_stall = group_done && q_status.full;
    accept     = text_valid && !text_stall;
    q_push     = accept && group_done;
    q_entry.word     = {acc, sextet};
    q_entry.key_base = out_idx;
    q_entry.last     = text_last;
  end

  // Advance the sextet packer and key positions
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pos     <= '0;
      in_idx  <= '0;
      out_idx <= '0;
    end else if (accept) begin
      if (text_last) begin
        acc     <= '0;
        pos     <= '0;
        in_idx  <= '0;
        out_idx <= '0;
      end else begin
        in_idx <= in_idx + xmb64_pkg::key_idx_t'(1);
        if (group_done) begin
          acc     <= '0;
          pos     <= '0;
          out_idx <= out_idx + xmb64_pkg::key_idx_t'(3);
        end else begin
          acc <= {acc[xmb64_pkg::AccW-xmb64_pkg::SextetW-1:0], sextet};
          pos <= pos + 2'd1;
        end
      end
    end
  end

endmodule

/* hw/rtl/xmb64_queue.sv */
// Two-entry group queue between the front and back ends.
// Uses xmb64_pkg for the entry and status types.
module xmb64_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  xmb64_pkg::group_t     push_entry,
  input  logic                  pop,
  output xmb64_pkg::group_t     head,
  output xmb64_pkg::q_status_t  status
);

  xmb64_pkg::group_t                 mem [xmb64_pkg::QueueDepth];
  logic [xmb64_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [xmb64_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [xmb64_pkg::QueueCntW-1:0]   count;

  // Report fill state and present the oldest group
  always_comb begin
    status.full  = (count == xmb64_pkg::QueueCntW'(xmb64_pkg::QueueDepth));
    status.empty = (count == '0);
    head         = mem[rd_ptr];
  end

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/xmb64_back.sv */
// Back end: splits each queued group into three bytes, masks each with its
// output key byte and drives the registered output channel. Uses xmb64_pkg.
module xmb64_back (
  input  logic                  clk,
  input  logic                  rst,
  input  xmb64_pkg::key_t       key,
  input  xmb64_pkg::group_t     q_head,
  input  xmb64_pkg::q_status_t  q_status,
  output logic                  q_pop,
  output logic                  plain_valid,
  output logic [7:0]            plain_byte,
  input  logic                  plain_stall,
  output logic                  plain_last
);

  logic [1:0]          sel;
  logic                load;
  logic                take;
  logic                sel_last;
  logic [7:0]          raw_byte;
  xmb64_pkg::key_idx_t key_idx;

  // Pick the byte of the group and its key position
  always_comb begin
    load     = !plain_valid || !plain_stall;
    take     = load && !q_status.empty;
    sel_last = (sel == xmb64_pkg::LastByteSel);
    q_pop    = take && sel_last;
    key_idx  = q_head.key_base + xmb64_pkg::key_idx_t'(sel);
    case (sel)
      2'd0:    raw_byte = q_head.word[23:16];
      2'd1:    raw_byte = q_head.word[15:8];
      default: raw_byte = q_head.word[7:0];
    endcase
  end

  // Advance the byte counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sel         <= '0;
      plain_valid <= 1'b0;
    end else if (load) begin
      plain_valid <= !q_status.empty;
      if (take) begin
        sel <= sel_last ? 2'd0 : sel + 2'd1;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (take) begin
      plain_byte <= raw_byte ^ key[key_idx];
      plain_last <= q_head.last && sel_last;
    end
  end

endmodule

/* tb/sv/tb_xor_masked_base64_decoder_top.sv */
`timescale 1ns / 100ps
// Testbench for xor_masked_base64_decoder_top: drives masked base64 text in random
// bursts against a stalling receiver and checks each plain byte against a built-in
// decoder model. Depends on xmb64_pkg and the decoder RTL.
module tb_xor_masked_base64_decoder_top;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 16;
  localparam int RandomItems = 30;
  localparam int HoldOffLen  = 150;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } plain_t;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           cfg_write   = 1'b0;
  logic [xmb64_pkg::CfgIdxW-1:0]  cfg_index   = xmb64_pkg::CfgKeyWord0;
  logic [xmb64_pkg::KeyWordW-1:0] cfg_data    = '0;
  logic                           text_valid  = 1'b0;
  logic [7:0]                     text_byte   = 8'h00;
  logic                           text_last   = 1'b0;
  logic                           text_stall;
  logic                           plain_valid;
  logic [7:0]                     plain_byte;
  logic                           plain_last;
  logic                           plain_stall = 1'b0;

  xor_masked_base64_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_valid  (text_valid),
    .text_byte   (text_byte),
    .text_last   (text_last),
    .text_stall  (text_stall),
    .plain_valid (plain_valid),
    .plain_byte  (plain_byte),
    .plain_last  (plain_last),
    .plain_stall (plain_stall)
  );

  // Decoder model state
  logic [xmb64_pkg::KeyWordW-1:0] key_word_m [xmb64_pkg::KeyWords];
  logic [xmb64_pkg::AccW-1:0]     sextets_m;
  logic [1:0]                     group_fill_m;
  xmb64_pkg::key_idx_t            text_pos_m;
  xmb64_pkg::key_idx_t            plain_pos_m;
  plain_t                         pending_plain [$];

  int fail_count     = 0;
  int text_count     = 0;
  int plain_count    = 0;
  int resource_count = 0;
  int group_count    = 0;
  int stall_seen     = 0;
  int cycle_count    = 0;

  // Sender and receiver pacing knobs
  int burst_left   = 0;
  int gap_max      = 0;
  int stall_pct    = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int stall_run    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] key_byte_at(xmb64_pkg::key_idx_t p);
    logic [xmb64_pkg::KeyWordW-1:0] w;
    w = key_word_m[p[4:3]] >> (8 * p[2:0]);
    return w[7:0];
  endfunction

  function automatic logic [xmb64_pkg::SextetW-1:0] char_value(logic [7:0] c);
    logic [7:0] v;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == "+") v = 8'd62;
    else if (c == "/") v = 8'd63;
    else v = 8'd0;
    return v[xmb64_pkg::SextetW-1:0];
  endfunction

  function automatic logic [7:0] b64_char(logic [xmb64_pkg::SextetW-1:0] v);
    if (v < 26) return "A" + v;
    else if (v < 52) return "a" + (v - 26);
    else if (v < 62) return "0" + (v - 52);
    else if (v == 62) return "+";
    else return "/";
  endfunction

  function automatic logic [xmb64_pkg::CfgIdxW-1:0] key_reg_index(int w);
    case (w)
      0: return xmb64_pkg::CfgKeyWord0;
      1: return xmb64_pkg::CfgKeyWord1;
      2: return xmb64_pkg::CfgKeyWord2;
      default: return xmb64_pkg::CfgKeyWord3;
    endcase
  endfunction

  // Advance the model by one accepted text byte; queue the plain bytes it yields
  function automatic void decode_text_byte(logic [7:0] b, logic l);
    logic [xmb64_pkg::SextetW-1:0] v;
    logic [xmb64_pkg::GroupW-1:0]  grp;
    plain_t                        e;
    int                            k;
    v = char_value(b ^ key_byte_at(text_pos_m));
    text_pos_m = text_pos_m + 1'b1;
    text_count++;
    if (group_fill_m != xmb64_pkg::GroupFullPos) begin
      sextets_m    = {sextets_m[xmb64_pkg::AccW-xmb64_pkg::SextetW-1:0], v};
      group_fill_m = group_fill_m + 1'b1;
    end else begin
      grp = {sextets_m, v};
      for (k = 0; k < 3; k++) begin
        e.data = grp[xmb64_pkg::GroupW-1-8*k -: 8] ^ key_byte_at(plain_pos_m);
        e.last = l && (k == 2);
        plain_pos_m = plain_pos_m + 1'b1;
        pending_plain.push_back(e);
      end
      group_count++;
      sextets_m    = '0;
      group_fill_m = '0;
    end
    // End of resource: restart both key positions and drop any partial group
    if (l) begin
      sextets_m    = '0;
      group_fill_m = '0;
      text_pos_m   = '0;
      plain_pos_m  = '0;
      resource_count++;
    end
  endfunction

  // Offer one text byte, with a random gap between bursts, and wait for acceptance
  task automatic send_text(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    text_last  <= l;
    do @(posedge clk); while (text_stall);
    decode_text_byte(b, l);
    burst_left--;
  endtask

  // Mask a plain character with the key byte of its input position
  task automatic send_char(input logic [7:0] c, input logic l);
    send_text(c ^ key_byte_at(text_pos_m), l);
  endtask

  task automatic send_string(input string s, input bit close);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], close && (i == s.len() - 1));
  endtask

  // Send whole groups of random base64, optionally padded and closed
  task automatic send_groups(input int groups, input int pads, input bit close);
    int         i;
    int         n;
    logic [7:0] c;
    n = groups * 4;
    for (i = 0; i < n; i++) begin
      c = (i >= n - pads) ? "=" : b64_char($urandom_range(63));
      send_char(c, close && (i == n - 1));
    end
  endtask

  // Drop valid, wait until every plain byte has come, then let the pipe settle
  task automatic wait_idle();
    text_valid <= 1'b0;
    burst_left = 0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_key(input logic [xmb64_pkg::KeyWordW-1:0] k0,
                           input logic [xmb64_pkg::KeyWordW-1:0] k1,
                           input logic [xmb64_pkg::KeyWordW-1:0] k2,
                           input logic [xmb64_pkg::KeyWordW-1:0] k3);
    logic [xmb64_pkg::KeyWordW-1:0] words [xmb64_pkg::KeyWords];
    int                             w;
    words[0] = k0;
    words[1] = k1;
    words[2] = k2;
    words[3] = k3;
    wait_idle();
    for (w = 0; w < xmb64_pkg::KeyWords; w++) begin
      cfg_write <= 1'b1;
      cfg_index <= key_reg_index(w);
      cfg_data  <= words[w];
      @(posedge clk);
      key_word_m[w] = words[w];
    end
    cfg_write <= 1'b0;
  endtask

  // Character map, field extremes, padding and end-of-resource cases on a zero key
  task automatic test_char_map();
    gap_max   = 3;
    stall_pct = 20;
    send_string("AZaz09+/=@[`{:", 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    // padded group closing the resource
    send_string("QQ==", 1'b1);
    // partial groups at end of resource are dropped
    send_string("QQ", 1'b1);
    send_string("Q", 1'b1);
  endtask

  // Extreme and random keys over resources long enough to wrap both key positions
  task automatic test_key_extremes();
    write_key('1, '1, '1, '1);
    send_groups(11, 0, 1'b1);
    write_key({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
    send_groups(11, 1, 1'b1);
    // steady stream with no idling on either side
    write_key({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    gap_max   = 0;
    stall_pct = 0;
    send_groups(11, 2, 1'b1);
  endtask

  // Hold the output off while text keeps coming, so the input backs up
  task automatic test_output_hold_off();
    wait_idle();
    gap_max      = 0;
    stall_pct    = 0;
    hold_request = HoldOffLen;
    send_groups(6, 0, 1'b1);
    wait_idle();
  endtask

  // Mostly well-formed resources, some cut short, some raw noise
  task automatic test_random_resources();
    int first;
    int kind;
    int n;
    int i;
    first = text_count;
    while (text_count - first < RandomItems) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(3) == 0) write_key('0, '0, '0, '0);
        else write_key({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
      end
      gap_max   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 50);
      kind = $urandom_range(9);
      if (kind < 6) begin
        send_groups($urandom_range(1, 6), $urandom_range(0, 2), 1'b1);
      end else if (kind < 8) begin
        send_groups($urandom_range(0, 3), 0, 1'b0);
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) send_char(b64_char($urandom_range(63)), i == n - 1);
      end else begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) send_text($urandom_range(255), i == n - 1);
      end
    end
  endtask

  // Receiver: long hold-offs on request, otherwise random stall runs
  always @(posedge clk) begin
    if (rst) begin
      plain_stall <= 1'b0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      plain_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      plain_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      plain_stall <= 1'b1;
    end else begin
      plain_stall <= 1'b0;
      if ($urandom_range(99) < stall_pct) stall_run = $urandom_range(1, 6);
    end
  end

  // Compare each accepted plain byte with the oldest expectation
  always @(posedge clk) begin
    plain_t e;
    if (!rst) begin
      if (text_valid && text_stall) stall_seen++;
      if (plain_valid && !plain_stall) begin
        if (pending_plain.size() == 0) begin
          $error("plain_byte: none expected, got %h (plain_last %b)", plain_byte, plain_last);
          fail_count++;
        end else begin
          e = pending_plain.pop_front();
          plain_count++;
          if (plain_byte !== e.data) begin
            $error("plain_byte: expected %h, got %h", e.data, plain_byte);
            fail_count++;
          end
          if (plain_last !== e.last) begin
            $error("plain_last: expected %b, got %b", e.last, plain_last);
            fail_count++;
          end
        end
      end
    end
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_xor_masked_base64_decoder_top failed");
    $finish;
  end

  initial begin
    int w;
    for (w = 0; w < xmb64_pkg::KeyWords; w++) key_word_m[w] = '0;
    sextets_m    = '0;
    group_fill_m = '0;
    text_pos_m   = '0;
    plain_pos_m  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_char_map();
    test_key_extremes();
    test_output_hold_off();
    test_random_resources();
    wait_idle();

    $display("Decoded %0d text bytes in %0d resources into %0d groups",
             text_count, resource_count, group_count);
    $display("%0d plain bytes checked, input held back on %0d cycles; %s",
             plain_count, stall_seen, "keys covered zero, all ones, alternating, random");
    if (fail_count == 0) begin
      $display("tb_xor_masked_base64_decoder_top passed");
    end else begin
      $display("tb_xor_masked_base64_decoder_top failed");
    end
    $finish;
  end

endmodule

/* xor_masked_base64_decoder_top.f */
hw/rtl/xmb64_pkg.sv
hw/rtl/xmb64_front.sv
hw/rtl/xmb64_queue.sv
hw/rtl/xmb64_back.sv
hw/rtl/xor_masked_base64_decoder_top.sv
tb/sv/tb_xor_masked_base64_decoder_top.sv
